// File: hdl/ttid_pkg.sv
package ttid_pkg;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_end;
  } pixel_out_t;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 13;
  localparam int FactorW   = 7;
  localparam int RowW      = 16;

  localparam logic [CfgIndexW-1:0] CFG_IN_WIDTH   = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_OUT_WIDTH  = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_OUT_HEIGHT = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_H_FACTOR   = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_V_FACTOR   = 3'd4;

  localparam logic [12:0]        RST_IN_WIDTH   = 13'd800;
  localparam logic [10:0]        RST_OUT_WIDTH  = 11'd350;
  localparam logic [10:0]        RST_OUT_HEIGHT = 11'd248;
  localparam logic [FactorW-1:0] RST_H_FACTOR   = 7'd2;
  localparam logic [FactorW-1:0] RST_V_FACTOR   = 7'd2;

  // per-byte truncating average of two packed pixels
  function automatic logic [31:0] avg_px(input logic [31:0] a, input logic [31:0] b);
    logic [8:0]  s;
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      s = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
      r[8*k +: 8] = s[8:1];
    end
    return r;
  endfunction

endpackage

// File: hdl/ttid_ram.sv
module ttid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AddrW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AddrW-1:0]         waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [AddrW-1:0]         raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/ttid_div.sv
module ttid_div #(
  parameter int NumW = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [NumW-1:0]             dividend,
  input  logic [ttid_pkg::FactorW-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [NumW-1:0]             quotient,
  output logic [ttid_pkg::FactorW-1:0] remainder
);

  localparam int StepW = $clog2(NumW + 1);

  logic [NumW-1:0]              num;
  logic [ttid_pkg::FactorW-1:0] rem;
  logic [ttid_pkg::FactorW-1:0] dvs;
  logic [StepW-1:0]             steps;
  logic [ttid_pkg::FactorW:0]   trial;
  logic                         fits;
  logic [ttid_pkg::FactorW-1:0] diff;
  logic [NumW-1:0]              shifted;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial   = {rem, num[NumW-1]};
    fits    = trial >= {1'b0, dvs};
    diff    = trial[ttid_pkg::FactorW-1:0] - dvs;
    shifted = NumW'({num, fits});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= StepW'(NumW);
      end else if (steps != '0) begin
        steps <= steps - StepW'(1);
        if (steps == StepW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (steps != '0) begin
      num <= shifted;
      rem <= fits ? diff : trial[ttid_pkg::FactorW-1:0];
    end
  end

  assign busy      = steps != '0;
  assign quotient  = num;
  assign remainder = rem;

endmodule

// File: hdl/two_tap_integer_downscaler.sv
// Channel  Signals                              Direction
// -------  -----------------------------------  ---------
// in       in_valid / in_ready / in_data        sink
// out      out_valid / out_ready / out_data     source
// cfg      cfg_we / cfg_index / cfg_wdata       sink, write only
//
// One pixel per clock while input is not stalled; a result passes the row buffer read stage, then
// the 4-entry output queue, and is delayed further if the queue backs up.
// A config write resyncs the column/row phase counters through two serial dividers: input is
// held off while a resync is pending or either divider is busy or signalling done.
// Reset is synchronous; the row buffer is not cleared and is written before read.
// Input also stalls while the output queue and the row buffer stage hold more than two results.
module two_tap_integer_downscaler #(
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int MAX_IN_WIDTH  = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ttid_pkg::pixel_in_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ttid_pkg::pixel_out_t                out_data,
  input  logic                                cfg_we,
  input  logic [ttid_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [ttid_pkg::CfgDataW-1:0]       cfg_wdata
);

  localparam int ColW  = (MAX_IN_WIDTH > 2) ? $clog2(MAX_IN_WIDTH) : 1;
  localparam int AddrW = (MAX_OUT_WIDTH > 2) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int FW    = ttid_pkg::FactorW;
  localparam int RW    = ttid_pkg::RowW;

  // configuration
  logic [12:0]   in_width;
  logic [10:0]   out_width;
  logic [10:0]   out_height;
  logic [FW-1:0] h_factor;
  logic [FW-1:0] v_factor;

  // position state
  logic [ColW-1:0] in_col;
  logic [FW-1:0]   col_phase;
  logic [ColW-1:0] out_col;
  logic [RW-1:0]   in_row;
  logic [FW-1:0]   row_phase;
  logic [RW-1:0]   out_row;
  logic [31:0]     held_sample;
  logic            resync;

  // derived config
  logic [FW-1:0] hf, vf, h_lo, h_hi, v_lo, v_hi;
  logic [FW+1:0] h3, v3;
  logic [12:0]   in_width_eff;
  logic [31:0]   wrap_lim, ow_lim;

  // accept stage
  logic            accept;
  logic [ColW-1:0] col, oi;
  logic [FW-1:0]   co, ro;
  logic [RW-1:0]   row, oj;
  logic [31:0]     px, hsum;
  logic            h_in, h_lo_hit, h_hi_hit, v_in, v_lo_hit, v_hi_hit;
  logic            col_last, frame_last, buf_write, emit;

  // dividers
  logic          div_start;
  logic          cdiv_busy, cdiv_done, rdiv_busy, rdiv_done;
  logic [ColW-1:0] cdiv_q;
  logic [FW-1:0]   cdiv_r, rdiv_r;
  logic [RW-1:0]   rdiv_q;

  // row buffer stage
  logic [31:0] ram_rdata;
  logic        s1_valid;
  logic [31:0] s1_hsum;
  logic        s1_fwd;
  logic        s1_end;
  logic [31:0] vsum;

  // output queue
  ttid_pkg::pixel_out_t q_mem [4];
  logic [1:0] q_wr, q_rd;
  logic [2:0] q_count;
  logic       q_pop;
  ttid_pkg::pixel_out_t q_in;

  always_comb begin
    hf   = (h_factor == '0) ? FW'(1) : h_factor;
    vf   = (v_factor == '0) ? FW'(1) : v_factor;
    h3   = {2'b0, hf} + {1'b0, hf, 1'b0};
    v3   = {2'b0, vf} + {1'b0, vf, 1'b0};
    h_lo = hf >> 2;
    v_lo = vf >> 2;
    h_hi = h3[FW+1:2];
    v_hi = v3[FW+1:2];
    in_width_eff = (in_width == '0) ? 13'd1 : in_width;
    wrap_lim = (32'(in_width_eff) > 32'(MAX_IN_WIDTH)) ? 32'(MAX_IN_WIDTH)
                                                      : 32'(in_width_eff);
    ow_lim   = (32'(out_width) > 32'(MAX_OUT_WIDTH)) ? 32'(MAX_OUT_WIDTH)
                                                    : 32'(out_width);
  end

  assign in_ready = !resync && !cdiv_busy && !rdiv_busy && !cdiv_done && !rdiv_done
                    && ((q_count + {2'b0, s1_valid}) <= 3'd2);
  assign accept   = in_valid && in_ready;

  always_comb begin
    col = in_data.frame_start ? '0 : in_col;
    co  = in_data.frame_start ? '0 : col_phase;
    oi  = in_data.frame_start ? '0 : out_col;
    row = in_data.frame_start ? '0 : in_row;
    ro  = in_data.frame_start ? '0 : row_phase;
    oj  = in_data.frame_start ? '0 : out_row;
    px  = {in_data.alpha_in, in_data.blue_in, in_data.green_in, in_data.red_in};

    h_in     = 32'(oi) < ow_lim;
    h_lo_hit = co == h_lo;
    h_hi_hit = co == h_hi;
    v_in     = oj < RW'(out_height);
    v_lo_hit = ro == v_lo;
    v_hi_hit = ro == v_hi;

    // coinciding taps: first tap is this very pixel
    hsum = ttid_pkg::avg_px(h_lo_hit ? px : held_sample, px);

    col_last   = (32'(col) + 32'd1) >= wrap_lim;
    frame_last = ((32'(oi) + 32'd1) == ow_lim) &&
                 (({1'b0, oj} + 17'd1) == 17'(out_height));
    buf_write  = accept && h_in && h_hi_hit && v_in && v_lo_hit;
    emit       = accept && h_in && h_hi_hit && v_in && v_hi_hit;
  end

  assign div_start = resync && !cdiv_busy && !rdiv_busy;

  ttid_div #(.NumW(ColW)) u_col_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (in_col),
    .divisor   (hf),
    .busy      (cdiv_busy),
    .done      (cdiv_done),
    .quotient  (cdiv_q),
    .remainder (cdiv_r)
  );

  ttid_div #(.NumW(RW)) u_row_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (in_row),
    .divisor   (vf),
    .busy      (rdiv_busy),
    .done      (rdiv_done),
    .quotient  (rdiv_q),
    .remainder (rdiv_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width   <= ttid_pkg::RST_IN_WIDTH;
      out_width  <= ttid_pkg::RST_OUT_WIDTH;
      out_height <= ttid_pkg::RST_OUT_HEIGHT;
      h_factor   <= ttid_pkg::RST_H_FACTOR;
      v_factor   <= ttid_pkg::RST_V_FACTOR;
      resync     <= 1'b0;
    end else begin
      if (cfg_we) begin
        resync <= 1'b1;
        case (cfg_index)
          ttid_pkg::CFG_IN_WIDTH:   in_width   <= cfg_wdata;
          ttid_pkg::CFG_OUT_WIDTH:  out_width  <= cfg_wdata[10:0];
          ttid_pkg::CFG_OUT_HEIGHT: out_height <= cfg_wdata[10:0];
          ttid_pkg::CFG_H_FACTOR:   h_factor   <= cfg_wdata[FW-1:0];
          ttid_pkg::CFG_V_FACTOR:   v_factor   <= cfg_wdata[FW-1:0];
          default:                  resync     <= 1'b1;
        endcase
      end else if (div_start) begin
        resync <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col      <= '0;
      col_phase   <= '0;
      out_col     <= '0;
      in_row      <= '0;
      row_phase   <= '0;
      out_row     <= '0;
      held_sample <= '0;
    end else begin
      if (cdiv_done) begin
        out_col   <= cdiv_q;
        col_phase <= cdiv_r;
      end
      if (rdiv_done) begin
        out_row   <= rdiv_q;
        row_phase <= rdiv_r;
      end
      if (accept) begin
        if (h_in && h_lo_hit) begin
          held_sample <= px;
        end
        if (col_last) begin
          in_col    <= '0;
          col_phase <= '0;
          out_col   <= '0;
          if (row != {RW{1'b1}}) begin
            in_row <= row + RW'(1);
            if (({1'b0, ro} + (FW+1)'(1)) == {1'b0, vf}) begin
              row_phase <= '0;
              out_row   <= oj + RW'(1);
            end else begin
              row_phase <= ro + FW'(1);
              out_row   <= oj;
            end
          end else begin
            in_row    <= row;
            row_phase <= ro;
            out_row   <= oj;
          end
        end else begin
          in_col    <= col + ColW'(1);
          in_row    <= row;
          row_phase <= ro;
          out_row   <= oj;
          if (({1'b0, co} + (FW+1)'(1)) == {1'b0, hf}) begin
            col_phase <= '0;
            out_col   <= oi + ColW'(1);
          end else begin
            col_phase <= co + FW'(1);
            out_col   <= oi;
          end
        end
      end
    end
  end

  // write and read always use the same address; both are enabled together only when the
  // vertical taps coincide, and that case is forwarded in the next stage
  ttid_ram #(.WIDTH(32), .DEPTH(MAX_OUT_WIDTH)) u_row_buffer (
    .clk   (clk),
    .we    (buf_write),
    .waddr (AddrW'(oi)),
    .wdata (hsum),
    .re    (emit),
    .raddr (AddrW'(oi)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_hsum <= hsum;
      s1_fwd  <= v_lo_hit;
      s1_end  <= frame_last;
    end
  end

  always_comb begin
    vsum = ttid_pkg::avg_px(s1_fwd ? s1_hsum : ram_rdata, s1_hsum);
    q_in.red_out   = vsum[7:0];
    q_in.green_out = vsum[15:8];
    q_in.blue_out  = vsum[23:16];
    q_in.alpha_out = vsum[31:24];
    q_in.frame_end = s1_end;
  end

  assign out_valid = q_count != '0;
  assign out_data  = q_mem[q_rd];
  assign q_pop     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      q_mem[q_wr] <= q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (s1_valid) begin
        q_wr <= q_wr + 2'd1;
      end
      if (q_pop) begin
        q_rd <= q_rd + 2'd1;
      end
      q_count <= q_count + {2'b0, s1_valid} - {2'b0, q_pop};
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int LINE_SLOTS   = 1024;
  localparam int ROW_LIMIT    = 4096;
  localparam int SETTLE       = 16;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 700;
  localparam int RESET_ITEMS  = 810;
  localparam int DW           = ttid_pkg::CfgDataW;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid;
  logic in_ready;
  ttid_pkg::pixel_in_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  ttid_pkg::pixel_out_t out_data;
  logic cfg_we;
  logic [ttid_pkg::CfgIndexW-1:0] cfg_index;
  logic [ttid_pkg::CfgDataW-1:0] cfg_wdata;

  // register shadows
  logic [12:0] width_in;
  logic [10:0] width_out;
  logic [10:0] height_out;
  logic [ttid_pkg::FactorW-1:0] h_fac;
  logic [ttid_pkg::FactorW-1:0] v_fac;

  // scaler state
  logic [11:0] col_pos;
  logic [ttid_pkg::RowW-1:0] row_pos;
  logic [31:0] tap_hold;
  logic [31:0] line_store [LINE_SLOTS];

  ttid_pkg::pixel_out_t owed_pixels[$];
  int mismatches = 0;
  int pixels_seen = 0;
  int quiet_cycles = 0;
  int tx_calm = 0;
  int rx_calm = 0;
  int rx_hold = 0;
  bit steady = 1'b0;

  two_tap_integer_downscaler #(
    .MAX_OUT_WIDTH(LINE_SLOTS),
    .MAX_IN_WIDTH(ROW_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // per-channel truncating mean, red in the low byte
  function automatic logic [31:0] halve_sum(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    int s;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      s = int'(a[8*k +: 8]) + int'(b[8*k +: 8]);
      r[8*k +: 8] = s[8:1];
    end
    return r;
  endfunction

  task automatic downscale_step(input ttid_pkg::pixel_in_t px);
    int hf, vf, ow, oh, wrap, col, row, oi, oj, co, ro;
    logic [31:0] pix, hsum, vsum;
    ttid_pkg::pixel_out_t res;
    hf = (h_fac == 0) ? 1 : int'(h_fac);
    vf = (v_fac == 0) ? 1 : int'(v_fac);
    ow = (width_out > LINE_SLOTS) ? LINE_SLOTS : int'(width_out);
    oh = int'(height_out);
    wrap = (width_in == 0) ? 1 : int'(width_in);
    if (wrap > ROW_LIMIT) wrap = ROW_LIMIT;
    if (px.frame_start) begin
      col_pos = '0;
      row_pos = '0;
    end
    col = int'(col_pos);
    row = int'(row_pos);
    pix = {px.alpha_in, px.blue_in, px.green_in, px.red_in};
    oi = col / hf;
    co = col % hf;
    oj = row / vf;
    ro = row % vf;
    if (oi < ow) begin
      if (co == hf / 4) tap_hold = pix;
      if (co == (3 * hf) / 4) begin
        hsum = halve_sum(tap_hold, pix);
        if (oj < oh) begin
          if (ro == vf / 4) line_store[oi] = hsum;
          if (ro == (3 * vf) / 4) begin
            vsum = halve_sum(line_store[oi], hsum);
            res.red_out   = vsum[7:0];
            res.green_out = vsum[15:8];
            res.blue_out  = vsum[23:16];
            res.alpha_out = vsum[31:24];
            res.frame_end = (oi + 1 == ow) && (oj + 1 == oh);
            owed_pixels.push_back(res);
          end
        end
      end
    end
    if (col + 1 >= wrap) begin
      col_pos = '0;
      if (row_pos != '1) row_pos = row_pos + 1'b1;
    end else begin
      col_pos = 12'(col + 1);
    end
  endtask

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 2) tx_calm = $urandom_range(30, 150);
    if (roll < 65) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic ttid_pkg::pixel_in_t rand_pixel(input bit fs);
    ttid_pkg::pixel_in_t px;
    px.frame_start = fs;
    px.red_in   = 8'($urandom_range(255));
    px.green_in = 8'($urandom_range(255));
    px.blue_in  = 8'($urandom_range(255));
    px.alpha_in = 8'($urandom_range(255));
    return px;
  endfunction

  // returns right after the accepting edge; valid stays up until the next falling edge
  task automatic send_pixel(input ttid_pkg::pixel_in_t px);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = px;
    do @(posedge clk); while (in_ready !== 1'b1);
    downscale_step(px);
  endtask

  task automatic send_frame(input int count, input int restart_at);
    for (int i = 0; i < count; i++) begin
      send_pixel(rand_pixel(i == 0 || i == restart_at));
    end
  endtask

  // wait until every owed pixel is out, then give the pipeline time to go quiet
  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (owed_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ttid_pkg::CfgIndexW-1:0] idx,
                           input logic [ttid_pkg::CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    case (idx)
      ttid_pkg::CFG_IN_WIDTH:   width_in = value[12:0];
      ttid_pkg::CFG_OUT_WIDTH:  width_out = value[10:0];
      ttid_pkg::CFG_OUT_HEIGHT: height_out = value[10:0];
      ttid_pkg::CFG_H_FACTOR:   h_fac = value[ttid_pkg::FactorW-1:0];
      ttid_pkg::CFG_V_FACTOR:   v_fac = value[ttid_pkg::FactorW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input int iw, input int ow, input int oh, input int hf,
                              input int vf);
    settle_block();
    write_reg(ttid_pkg::CFG_IN_WIDTH, DW'(iw));
    write_reg(ttid_pkg::CFG_OUT_WIDTH, DW'(ow));
    write_reg(ttid_pkg::CFG_OUT_HEIGHT, DW'(oh));
    write_reg(ttid_pkg::CFG_H_FACTOR, DW'(hf));
    write_reg(ttid_pkg::CFG_V_FACTOR, DW'(vf));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // reset register values, counters cleared by reset alone; one full row, then a few
  // outputs from the second row
  task automatic test_reset_values();
    for (int i = 0; i < RESET_ITEMS; i++) send_pixel(rand_pixel(1'b0));
  endtask

  task automatic test_corner_pixels();
    logic [7:0] vals [6];
    ttid_pkg::pixel_in_t px;
    vals = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};
    // 5x5 in, 2x2 out: last column and last row fall outside
    program_regs(5, 2, 2, 2, 2);
    for (int k = 0; k < 25; k++) begin
      px.frame_start = (k == 0);
      px.red_in   = vals[k % 6];
      px.green_in = vals[(k + 1) % 6];
      px.blue_in  = vals[(k + 3) % 6];
      px.alpha_in = vals[(5 * k + 2) % 6];
      send_pixel(px);
    end
  endtask

  // zero width and factors act as one; both taps coincide
  task automatic test_zero_factors();
    program_regs(0, 1, 4, 0, 0);
    send_frame(6, -1);
  endtask

  task automatic test_tall_factor();
    program_regs(1, 1, 2, 1, 64);
    send_frame(130, -1);
  endtask

  task automatic test_output_backpressure();
    program_regs(16, 16, 4, 1, 1);
    rx_hold = 300;
    steady = 1'b1;
    send_frame(64, -1);
    steady = 1'b0;
  endtask

  function automatic int pick_factor();
    if ($urandom_range(9) == 0) return 0;
    return $urandom_range(1, 5);
  endfunction

  task automatic test_random_frames();
    int sent, iw, ow, oh, hf, vf, span, rows, wrap, count, restart, kind, nframes;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      hf = pick_factor();
      vf = pick_factor();
      ow = $urandom_range(1, 6);
      oh = $urandom_range(1, 3);
      span = ((hf == 0) ? 1 : hf) * ow;
      kind = $urandom_range(9);
      if (kind < 7) iw = span + $urandom_range(0, 2);
      else if (kind < 9) iw = $urandom_range(1, span);
      else iw = 0;
      program_regs(iw, ow, oh, hf, vf);
      wrap = (iw == 0) ? 1 : iw;
      rows = ((vf == 0) ? 1 : vf) * oh + $urandom_range(0, 2);
      nframes = $urandom_range(1, 3);
      repeat (nframes) begin
        count = wrap * rows;
        restart = -1;
        kind = $urandom_range(9);
        if (kind == 0) count = $urandom_range(1, count);
        else if (kind == 1) restart = $urandom_range(1, count - 1);
        send_frame(count, restart);
        sent += count;
      end
    end
  endtask

  always @(negedge clk) begin
    int roll;
    if (rx_hold > 0) begin
      out_ready = 1'b0;
      rx_hold--;
    end else if (steady || rx_calm > 0) begin
      out_ready = 1'b1;
      if (rx_calm > 0) rx_calm--;
    end else begin
      roll = $urandom_range(99);
      if (roll < 3) rx_calm = $urandom_range(30, 150);
      if (roll < 70) begin
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b0;
        rx_hold = (roll < 96) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk) begin
    ttid_pkg::pixel_out_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      pixels_seen++;
      if (owed_pixels.size() == 0) begin
        flag_mismatch($sformatf("unexpected pixel %h", out_data));
      end else begin
        want = owed_pixels.pop_front();
        if (out_data.red_out !== want.red_out)
          flag_mismatch($sformatf("pixel %0d red %h want %h", pixels_seen,
                                  out_data.red_out, want.red_out));
        if (out_data.green_out !== want.green_out)
          flag_mismatch($sformatf("pixel %0d green %h want %h", pixels_seen,
                                  out_data.green_out, want.green_out));
        if (out_data.blue_out !== want.blue_out)
          flag_mismatch($sformatf("pixel %0d blue %h want %h", pixels_seen,
                                  out_data.blue_out, want.blue_out));
        if (out_data.alpha_out !== want.alpha_out)
          flag_mismatch($sformatf("pixel %0d alpha %h want %h", pixels_seen,
                                  out_data.alpha_out, want.alpha_out));
        if (out_data.frame_end !== want.frame_end)
          flag_mismatch($sformatf("pixel %0d frame_end %b want %b", pixels_seen,
                                  out_data.frame_end, want.frame_end));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction in %0d cycles, %0d pixels owed", quiet_cycles,
               owed_pixels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    width_in = ttid_pkg::RST_IN_WIDTH;
    width_out = ttid_pkg::RST_OUT_WIDTH;
    height_out = ttid_pkg::RST_OUT_HEIGHT;
    h_fac = ttid_pkg::RST_H_FACTOR;
    v_fac = ttid_pkg::RST_V_FACTOR;
    col_pos = '0;
    row_pos = '0;
    tap_hold = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_corner_pixels();
    test_zero_factors();
    test_tall_factor();
    test_output_backpressure();
    test_random_frames();

    settle_block();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
